/* sv/sst_pkg.sv */
// shared types and codes for the scoped symbol table
`timescale 1ns / 1ps

package sst_pkg;

  // request codes carried on s_tuser
  localparam logic [2:0] FN_PUSH   = 3'd0;
  localparam logic [2:0] FN_POP    = 3'd1;
  localparam logic [2:0] FN_DECL   = 3'd2;
  localparam logic [2:0] FN_LK_ALL = 3'd3;
  localparam logic [2:0] FN_LK_CUR = 3'd4;

  // result status codes carried on m_tuser
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_NOSCOPE  = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] decl;
    logic [2:0]  sym_type;
    logic [3:0]  kind;
    logic [7:0]  index;
  } res_t;

  localparam res_t RES_ZERO = '{status: ST_OK, decl: 16'd0, sym_type: 3'd0,
                                kind: 4'd0, index: 8'd0};

endpackage

/* sv/sst_symbol_mem.sv */
// symbol entry memory with registered read and name key compare
`timescale 1ns / 1ps

module sst_symbol_mem
  import sst_pkg::*;
#(
  parameter int ENT_W = 39,
  parameter int AW    = 8,
  parameter int KEY_W = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [ENT_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  input  logic [KEY_W-1:0] key,
  output logic [ENT_W-1:0] rdata,
  output logic             hit
);

  logic [ENT_W-1:0] store [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

  // name key sits in the low bits of an entry
  assign hit = (rdata[KEY_W-1:0] == key);

endmodule

/* sv/scoped_symbol_table.sv */
// scoped symbol table: top level with request sequencer and scope stack
`timescale 1ns / 1ps

// usage
//   input channel s_*: one request per transaction, the request code on
//   s_tuser (push scope, pop scope, declare, lookup all, lookup current)
//   and the name key, kind, type and declaration handle on s_tdata
//   output channel m_*: exactly one result per request, status on m_tuser
//   and the matching or new entry (index, kind, type, handle) on m_tdata
//   push, pop and the ignored codes go from the execute state to the result
//   state, pop by way of a wait for the enclosing mark when one is left;
//   declare and lookup scan the entries newest first through one registered
//   memory read port and one key comparator, one entry per cycle, searching
//   at most SYMBOL_DEPTH entries
//   throughput: one request in flight; s_tready is high only while the
//   sequencer is idle
//   the result sits in an output register, so the next request is taken
//   while a result waits; a stalled receiver holds the finished result of
//   the next request in the sequencer until the output register frees
//   reset clears the entry and scope counts; the memories are not cleared
//   since only entries below the live count are ever read

module scoped_symbol_table
  import sst_pkg::*;
#(
  parameter int SYMBOL_DEPTH   = 256,
  parameter int SCOPE_DEPTH    = 32,
  parameter int NAME_KEY_WIDTH = 16,
  parameter int HANDLE_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // name_key[15:0], sym_kind[19:16], sym_type[22:20],
                                 // decl_ref[38:23], zero pad[39]
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // found_index[7:0], found_kind[11:8], found_type[14:12],
                                 // found_decl[30:15], zero pad[31]
  output logic [2:0]  m_tuser    // status[2:0]
);

  localparam int SYM_AW = $clog2(SYMBOL_DEPTH);
  localparam int CNT_W  = SYM_AW + 1;
  localparam int SCP_AW = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;
  localparam int SCP_CW = $clog2(SCOPE_DEPTH + 1);
  localparam int KEY_W  = (NAME_KEY_WIDTH < 16) ? NAME_KEY_WIDTH : 16;
  localparam int HDL_W  = (HANDLE_WIDTH < 16) ? HANDLE_WIDTH : 16;
  localparam int ENT_W  = KEY_W + 4 + 3 + HDL_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_POPW = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]        state;

  // latched request
  logic [2:0]        func_r;
  logic [KEY_W-1:0]  key_r;
  logic [3:0]        kind_r;
  logic [2:0]        type_r;
  logic [HDL_W-1:0]  hdl_r;

  // table state
  logic [CNT_W-1:0]  sym_count;
  logic [SCP_CW-1:0] scope_count;
  logic [CNT_W-1:0]  cur_mark;    // mark of the innermost open scope
  logic [CNT_W-1:0]  first_mark;  // mark of the outermost open scope

  // scan state
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  ptr;
  logic              rd_pend;
  logic [SYM_AW-1:0] rd_idx;

  res_t              res;

  // scope mark memory
  logic [CNT_W-1:0]  marks [2**SCP_AW];
  logic [CNT_W-1:0]  mark_rdata;
  logic              mark_we;
  logic              mark_re;

  // symbol memory interface
  logic              mem_we;
  logic [SYM_AW-1:0] mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [SYM_AW-1:0] mem_raddr;
  logic [ENT_W-1:0]  mem_rdata;
  logic              mem_hit;

  logic              hit_now;
  logic              scan_more;
  logic              sym_full;
  logic              scope_full;
  logic              out_free;

  assign s_tready   = (state == S_IDLE);
  assign hit_now    = rd_pend && mem_hit;
  assign scan_more  = (ptr > lo);
  assign sym_full   = (sym_count == CNT_W'(SYMBOL_DEPTH));
  assign scope_full = (scope_count == SCP_CW'(SCOPE_DEPTH));
  assign out_free   = !m_tvalid || m_tready;

  // memory controls
  assign mark_we   = (state == S_EXEC) && (func_r == FN_PUSH) && !scope_full;
  assign mark_re   = (state == S_EXEC) && (func_r == FN_POP) && (scope_count > SCP_CW'(1));
  assign mem_re    = (state == S_SCAN) && !hit_now && scan_more;
  assign mem_raddr = SYM_AW'(ptr - CNT_W'(1));
  assign mem_we    = (state == S_SCAN) && !hit_now && !scan_more && (func_r == FN_DECL)
                     && !sym_full;
  assign mem_waddr = sym_count[SYM_AW-1:0];
  assign mem_wdata = {hdl_r, type_r, kind_r, key_r};

  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks[SCP_AW'(scope_count)] <= sym_count;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_re) begin
      mark_rdata <= marks[SCP_AW'(scope_count - SCP_CW'(2))];
    end
  end

  sst_symbol_mem #(
    .ENT_W (ENT_W),
    .AW    (SYM_AW),
    .KEY_W (KEY_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .key   (key_r),
    .rdata (mem_rdata),
    .hit   (mem_hit)
  );

  // request latch
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func_r <= s_tuser;
      key_r  <= s_tdata[KEY_W-1:0];
      kind_r <= s_tdata[19:16];
      type_r <= s_tdata[22:20];
      hdl_r  <= s_tdata[23 +: HDL_W];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sym_count   <= '0;
      scope_count <= '0;
      rd_pend     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            // result starts out empty for every new request
            res   <= RES_ZERO;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          rd_pend <= 1'b0;
          ptr     <= sym_count;
          case (func_r)
            FN_PUSH: begin
              state <= S_RESP;
              if (scope_full) begin
                res.status <= ST_FULL;
              end else begin
                if (scope_count == '0) begin
                  first_mark <= sym_count;
                end
                cur_mark    <= sym_count;
                scope_count <= scope_count + SCP_CW'(1);
              end
            end
            FN_POP: begin
              if (scope_count == '0) begin
                res.status <= ST_NOSCOPE;
                state      <= S_RESP;
              end else begin
                scope_count <= scope_count - SCP_CW'(1);
                sym_count   <= cur_mark;
                // the enclosing scope's mark comes back from memory
                state       <= mark_re ? S_POPW : S_RESP;
              end
            end
            FN_DECL: begin
              // no open scope: nothing to check against
              lo    <= (scope_count == '0) ? sym_count : cur_mark;
              state <= S_SCAN;
            end
            FN_LK_ALL: begin
              lo    <= (scope_count == '0) ? sym_count : first_mark;
              state <= S_SCAN;
            end
            FN_LK_CUR: begin
              lo    <= (scope_count == '0) ? sym_count : cur_mark;
              state <= S_SCAN;
            end
            default: begin
              state <= S_RESP;
            end
          endcase
        end
        S_SCAN: begin
          if (hit_now) begin
            // newest match wins; a hit on declare is a duplicate
            res.status   <= (func_r == FN_DECL) ? ST_DUP : ST_OK;
            res.index    <= 8'(rd_idx);
            res.kind     <= mem_rdata[KEY_W +: 4];
            res.sym_type <= mem_rdata[KEY_W+4 +: 3];
            res.decl     <= 16'(mem_rdata[KEY_W+7 +: HDL_W]);
            rd_pend      <= 1'b0;
            state        <= S_RESP;
          end else if (scan_more) begin
            ptr     <= ptr - CNT_W'(1);
            rd_idx  <= mem_raddr;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            state   <= S_RESP;
            if (func_r != FN_DECL) begin
              res.status <= ST_NOTFOUND;
            end else if (sym_full) begin
              res.status <= ST_FULL;
            end else begin
              res.status   <= ST_OK;
              res.index    <= 8'(sym_count);
              res.kind     <= kind_r;
              res.sym_type <= type_r;
              res.decl     <= 16'(hdl_r);
              sym_count    <= sym_count + CNT_W'(1);
            end
          end
        end
        S_POPW: begin
          cur_mark <= mark_rdata;
          state    <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      m_tuser <= res.status;
      m_tdata <= {1'b0, res.decl, res.sym_type, res.kind, res.index};
    end
  end

endmodule

/* tb/tb_scoped_symbol_table.sv */
// self-checking testbench for the scoped symbol table: directed, fill, pressure and random runs
`timescale 1ns / 1ps

module tb_scoped_symbol_table;
  import sst_pkg::*;

  // block sizes at their default values
  localparam int SYMBOL_SLOTS = 256;
  localparam int SCOPE_SLOTS  = 32;

  // request codes the block ignores
  localparam logic [2:0] FN_RSVD5 = 3'd5;
  localparam logic [2:0] FN_RSVD7 = 3'd7;

  // chance in a hundred that a side idles in a cycle
  localparam int IDLE_PCT = 18;
  // length of a receiver hold-off that backs the block up
  localparam int HOLD_CYCLES = 400;
  // cycles allowed after the last result for stray results to show up
  localparam int TAIL_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // name_key[15:0], sym_kind[19:16], sym_type[22:20],
                               // decl_ref[38:23], zero pad[39]
  logic [2:0]  s_tuser = '0;   // func[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // found_index[7:0], found_kind[11:8], found_type[14:12],
                               // found_decl[30:15], zero pad[31]
  logic [2:0]  m_tuser;        // status[2:0]

  scoped_symbol_table DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // ---------------------------------------------------------------------------
  // shadow copy of the symbol stack and scope marks
  // ---------------------------------------------------------------------------
  logic [15:0] mirror_key  [SYMBOL_SLOTS];
  logic [3:0]  mirror_kind [SYMBOL_SLOTS];
  logic [2:0]  mirror_type [SYMBOL_SLOTS];
  logic [15:0] mirror_decl [SYMBOL_SLOTS];
  int          scope_base  [SCOPE_SLOTS];
  int          live_syms   = 0;
  int          open_scopes = 0;

  // what the run went through, for the summary
  int n_push = 0, n_pop = 0, n_decl = 0, n_lookup = 0, n_ignored = 0;
  int n_hit = 0, n_dup = 0, n_full = 0, n_noscope = 0, n_miss = 0;

  // expected result of one accepted request, with its origin for reporting
  typedef struct {
    res_t       res;
    logic [2:0] fn;
    int         seq;
  } awaited_t;

  awaited_t pending_results[$];
  int       sent        = 0;
  int       received    = 0;
  int       mismatches  = 0;

  // idling control shared by both sides
  bit calm        = 1'b0;
  int holds_asked = 0;
  int holds_done  = 0;

  // newest entry in [lo, hi) with this key, or -1
  function automatic int find_newest(logic [15:0] key, int lo, int hi);
    for (int i = hi - 1; i >= lo; i--)
      if (mirror_key[i] == key) return i;
    return -1;
  endfunction

  function automatic res_t entry_result(logic [2:0] status, int idx);
    res_t r;
    r.status   = status;
    r.index    = 8'(idx);
    r.kind     = mirror_kind[idx];
    r.sym_type = mirror_type[idx];
    r.decl     = mirror_decl[idx];
    return r;
  endfunction

  // apply one request to the shadow state and give the result it must produce
  function automatic res_t resolve_request(logic [2:0] fn, logic [15:0] key, logic [3:0] kind,
                                           logic [2:0] typ, logic [15:0] decl);
    res_t r;
    int   hit;
    int   lo;
    r   = RES_ZERO;
    hit = -1;
    case (fn)
      FN_PUSH: begin
        n_push++;
        if (open_scopes >= SCOPE_SLOTS) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          scope_base[open_scopes] = live_syms;
          open_scopes++;
        end
      end
      FN_POP: begin
        n_pop++;
        if (open_scopes == 0) begin
          r.status = ST_NOSCOPE;
          n_noscope++;
        end else begin
          open_scopes--;
          live_syms = scope_base[open_scopes];
        end
      end
      FN_DECL: begin
        n_decl++;
        if (open_scopes > 0) hit = find_newest(key, scope_base[open_scopes - 1], live_syms);
        if (hit >= 0) begin
          // duplicate check comes before the full check
          r = entry_result(ST_DUP, hit);
          n_dup++;
        end else if (live_syms >= SYMBOL_SLOTS) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          mirror_key[live_syms]  = key;
          mirror_kind[live_syms] = kind;
          mirror_type[live_syms] = typ;
          mirror_decl[live_syms] = decl;
          r = entry_result(ST_OK, live_syms);
          live_syms++;
        end
      end
      FN_LK_ALL, FN_LK_CUR: begin
        n_lookup++;
        if (open_scopes > 0) begin
          lo  = (fn == FN_LK_ALL) ? scope_base[0] : scope_base[open_scopes - 1];
          hit = find_newest(key, lo, live_syms);
        end
        if (hit >= 0) begin
          r = entry_result(ST_OK, hit);
          n_hit++;
        end else begin
          r.status = ST_NOTFOUND;
          n_miss++;
        end
      end
      default: n_ignored++;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    forever #2 clk = ~clk;
  end

  // generous bound: far above the slowest legal run at 4 ns per cycle
  initial begin
    #(20_000_000);
    $display("tb_scoped_symbol_table failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random backpressure, calm stretches and long hold-offs
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (holds_done < holds_asked) begin
        // hold-off asked by a test, counted out here
        holds_done++;
        stall_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endtask

  // ---------------------------------------------------------------------------
  // result checker: every output transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    awaited_t want;
    res_t     got;
    if (!rst && m_tvalid && m_tready) begin
      received++;
      got.status   = m_tuser;
      got.index    = m_tdata[7:0];
      got.kind     = m_tdata[11:8];
      got.sym_type = m_tdata[14:12];
      got.decl     = m_tdata[30:15];
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: status %0d data %h",
                                m_tuser, m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.res.status || got.index !== want.res.index ||
            got.kind !== want.res.kind || got.sym_type !== want.res.sym_type ||
            got.decl !== want.res.decl || m_tdata[31] !== 1'b0)
          note_mismatch({
            $sformatf("mismatch req #%0d func %0d: exp st %0d idx %0d kind %0d type %0d ",
                      want.seq, want.fn, want.res.status, want.res.index, want.res.kind,
                      want.res.sym_type),
            $sformatf("decl %h, got st %0d idx %0d kind %0d type %0d decl %h pad %b",
                      want.res.decl, got.status, got.index, got.kind, got.sym_type,
                      got.decl, m_tdata[31])});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender: one request per call, random gap in front, changes at negedge
  // ---------------------------------------------------------------------------
  task automatic send_req(logic [2:0] fn, logic [15:0] key, logic [3:0] kind,
                          logic [2:0] typ, logic [15:0] decl);
    awaited_t a;
    int       gap;
    gap = 0;
    if (!calm)
      while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    @(negedge clk);
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, decl, typ, kind, key};
    s_tuser  <= fn;
    do @(posedge clk); while (!s_tready);
    // transaction taken at this edge
    a.res = resolve_request(fn, key, kind, typ, decl);
    a.fn  = fn;
    a.seq = sent;
    pending_results.push_back(a);
    sent++;
  endtask

  // stop offering and let every expected result come back
  task automatic wait_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [2:0] any_type();
    // mostly the named types, now and then any 3-bit code
    return ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
  endfunction

  // ---------------------------------------------------------------------------
  // test: every request kind, field extremes and the corner cases
  // ---------------------------------------------------------------------------
  task automatic test_basics();
    send_req(FN_LK_ALL, 16'h1234, 4'd0, 3'd0, 16'h0000);    // lookup with nothing open
    send_req(FN_POP,    16'h0000, 4'd0, 3'd0, 16'h0000);    // pop with nothing open
    send_req(FN_DECL,   16'h1234, 4'd9, 3'd2, 16'h5a5a);    // declare outside any scope
    send_req(FN_LK_ALL, 16'h1234, 4'd0, 3'd0, 16'h0000);    // still invisible
    send_req(FN_PUSH,   16'hffff, 4'hf, 3'd7, 16'hffff);
    send_req(FN_LK_ALL, 16'h1234, 4'd0, 3'd0, 16'h0000);    // below the outer mark
    send_req(FN_DECL,   16'h0000, 4'hf, 3'd4, 16'hffff);
    send_req(FN_DECL,   16'hffff, 4'h0, 3'd0, 16'h0000);
    send_req(FN_DECL,   16'h0000, 4'h3, 3'd1, 16'h1111);    // duplicate in this scope
    send_req(FN_PUSH,   16'h0000, 4'd0, 3'd0, 16'h0000);
    send_req(FN_DECL,   16'h0000, 4'h5, 3'd7, 16'h8001);    // shadows the outer one
    send_req(FN_LK_ALL, 16'h0000, 4'd0, 3'd0, 16'h0000);    // innermost wins
    send_req(FN_LK_CUR, 16'hffff, 4'd0, 3'd0, 16'h0000);    // only in the outer scope
    send_req(FN_LK_ALL, 16'hffff, 4'd0, 3'd0, 16'h0000);
    for (int f = FN_RSVD5; f <= FN_RSVD7; f++)
      send_req(3'(f), 16'($urandom), 4'($urandom), 3'($urandom), 16'($urandom));
    send_req(FN_POP,    16'h0000, 4'd0, 3'd0, 16'h0000);    // drops the shadowing entry
    send_req(FN_LK_ALL, 16'h0000, 4'd0, 3'd0, 16'h0000);
    send_req(FN_LK_CUR, 16'h0000, 4'd0, 3'd0, 16'h0000);
    send_req(FN_POP,    16'h0000, 4'd0, 3'd0, 16'h0000);
    send_req(FN_POP,    16'h0000, 4'd0, 3'd0, 16'h0000);    // nothing left to pop
    wait_results();
  endtask

  // ---------------------------------------------------------------------------
  // test: scope stack overflow and unwinding past the bottom
  // ---------------------------------------------------------------------------
  task automatic test_scope_overflow();
    for (int i = 0; i <= SCOPE_SLOTS; i++) begin
      send_req(FN_PUSH, 16'($urandom), 4'($urandom), 3'($urandom), 16'($urandom));
      if (i % 8 == 0)
        send_req(FN_DECL, 16'(16'h0700 + i), 4'(i), any_type(), 16'($urandom));
    end
    send_req(FN_LK_ALL, 16'h0700, 4'd0, 3'd0, 16'h0000);
    send_req(FN_LK_CUR, 16'h0718, 4'd0, 3'd0, 16'h0000);
    for (int i = 0; i <= SCOPE_SLOTS; i++) begin
      send_req(FN_POP, 16'($urandom), 4'($urandom), 3'($urandom), 16'($urandom));
      if (i == SCOPE_SLOTS / 2)
        send_req(FN_LK_ALL, 16'h0708, 4'd0, 3'd0, 16'h0000);
    end
    wait_results();
  endtask

  // ---------------------------------------------------------------------------
  // test: fill the symbol store to the last slot and push past it
  // ---------------------------------------------------------------------------
  task automatic test_store_full();
    int n;
    n = 0;
    send_req(FN_PUSH, 16'h0000, 4'd0, 3'd0, 16'h0000);
    while (live_syms < SYMBOL_SLOTS) begin
      send_req(FN_DECL, 16'(n * 97 + 3), 4'(n), any_type(), 16'($urandom));
      n++;
    end
    send_req(FN_DECL,   16'd3,    4'd1, 3'd1, 16'h0001);  // duplicate wins over full
    send_req(FN_DECL,   16'hbeef, 4'd1, 3'd1, 16'h0002);  // no room
    send_req(FN_PUSH,   16'h0000, 4'd0, 3'd0, 16'h0000);
    send_req(FN_DECL,   16'hbeef, 4'd1, 3'd1, 16'h0003);
    send_req(FN_DECL,   16'd3,    4'd1, 3'd1, 16'h0004);  // outer scope only, so full
    send_req(FN_LK_ALL, 16'd3,    4'd0, 3'd0, 16'h0000);
    send_req(FN_LK_CUR, 16'd3,    4'd0, 3'd0, 16'h0000);
    send_req(FN_LK_ALL, 16'((n - 1) * 97 + 3), 4'd0, 3'd0, 16'h0000);
    send_req(FN_POP,    16'h0000, 4'd0, 3'd0, 16'h0000);
    send_req(FN_POP,    16'h0000, 4'd0, 3'd0, 16'h0000);
    wait_results();
  endtask

  // ---------------------------------------------------------------------------
  // test: receiver holds off while requests keep coming, block backs up
  // ---------------------------------------------------------------------------
  task automatic test_backpressure();
    send_req(FN_PUSH, 16'h0000, 4'd0, 3'd0, 16'h0000);
    holds_asked++;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0)
        send_req(FN_DECL, 16'(16'h4400 + i), 4'($urandom), any_type(), 16'($urandom));
      else
        send_req((i % 2 == 0) ? FN_LK_ALL : FN_LK_CUR, 16'(16'h4400 + $urandom_range(0, 30)),
                 4'd0, 3'd0, 16'h0000);
    end
    send_req(FN_POP, 16'h0000, 4'd0, 3'd0, 16'h0000);
    wait_results();
  endtask

  // ---------------------------------------------------------------------------
  // test: random request streams, mostly well-formed scope nesting
  // ---------------------------------------------------------------------------
  task automatic test_random();
    logic [15:0] key_pool [12];
    logic [15:0] key;
    logic [2:0]  fn;
    int          r;
    foreach (key_pool[k]) key_pool[k] = 16'($urandom);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // a stretch with no idling on either side, and one more hold-off
      calm = (i >= 700 && i < 1000);
      if (i == 1300) holds_asked++;
      // small key pool so declares collide and lookups hit
      key = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, 11)] : 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 3)       fn = 3'($urandom_range(FN_RSVD5, FN_RSVD7));
      else if (r < 13) fn = FN_PUSH;
      else if (r < 22) fn = FN_POP;
      else if (r < 55) fn = FN_DECL;
      else if (r < 80) fn = FN_LK_ALL;
      else             fn = FN_LK_CUR;
      // keep the nesting shallow and the store small so scans stay short
      if (fn == FN_PUSH && open_scopes > 8) fn = FN_POP;
      if (fn == FN_DECL && live_syms > 120) fn = FN_POP;
      if (fn == FN_POP && open_scopes == 0 && $urandom_range(0, 1) == 0) fn = FN_PUSH;
      send_req(fn, key, 4'($urandom), any_type(), 16'($urandom));
    end
    calm = 1'b0;
    wait_results();
  endtask

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basics();
    test_scope_overflow();
    test_store_full();
    test_backpressure();
    test_random();

    // any stray result from here on is flagged by the checker
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d push, %0d pop, %0d declare, %0d lookup, %0d ignored",
             sent, n_push, n_pop, n_decl, n_lookup, n_ignored);
    $display("outcomes: %0d hits, %0d misses, %0d duplicates, %0d full, %0d no-scope; %0d errors",
             n_hit, n_miss, n_dup, n_full, n_noscope, mismatches);
    if (mismatches == 0 && pending_results.size() == 0 && received == sent)
      $display("tb_scoped_symbol_table passed");
    else
      $display("tb_scoped_symbol_table failed");
    $finish;
  end

endmodule
